// File: rtl/baro_temp_press_compensation_core_assert.svh
// Assertion macros for the barometer compensation core checker.
// Used by the checker file only; no other dependencies.
`ifndef BARO_TEMP_PRESS_COMPENSATION_CORE_ASSERT_SVH
`define BARO_TEMP_PRESS_COMPENSATION_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define BPTC_ASSERT_IMPL(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define BPTC_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bptc_pkg.sv
// Shared types, constants and helpers for the barometer compensation core.
// No dependencies.
`timescale 1ns / 1ps

package bptc_pkg;

	localparam int unsigned NUM_CAL_REGS = 6;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned DIV_STAGES   = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_T1_T2 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_T3_P1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_P2_P3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_P4_P5 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_P6_P7 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_P8_P9 = 3'd5;

	// Trim words, widened to 32 bits (signed ones sign-extended)
	typedef struct packed {
		logic [31:0] t1;
		logic [31:0] t2;
		logic [31:0] t3;
		logic [31:0] p1;
		logic [31:0] p2;
		logic [31:0] p3;
		logic [31:0] p4;
		logic [31:0] p5;
		logic [31:0] p6;
		logic [31:0] p7;
		logic [31:0] p8;
		logic [31:0] p9;
	} trim_t;

	// One word in flight through the divider
	typedef struct packed {
		logic [23:0] temp;
		logic        dbl;
		logic        inv;
		logic [31:0] dvs;
		logic [31:0] rem;
		logic [31:0] num;
		logic [31:0] quo;
	} div_word_t;

	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
		asr32 = 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sext16(input logic [15:0] v);
		sext16 = {{16{v[15]}}, v};
	endfunction

endpackage

// File: rtl/bptc_if.sv
// Valid/ready channel interfaces for raw readings and compensated results.
// No dependencies.
`timescale 1ns / 1ps

interface bptc_in_if;
	logic        valid;
	logic        ready;
	logic [19:0] raw_temp;
	logic [19:0] raw_press;

	modport source (output valid, raw_temp, raw_press, input ready);
	modport sink   (input valid, raw_temp, raw_press, output ready);
endinterface

interface bptc_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] temp_centi;
	logic [31:0] press_pa;
	logic        press_invalid;

	modport source (output valid, temp_centi, press_pa, press_invalid, input ready);
	modport sink   (input valid, temp_centi, press_pa, press_invalid, output ready);
endinterface

// File: rtl/baro_temp_press_compensation_core.sv
// Top level of the barometer compensation core: trim registers and pipeline.
// Depends on bptc_pkg, bptc_if, bptc_front, bptc_div, bptc_back.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    raw_temp[19:0], raw_press[19:0]
//   out_ch   out  valid/ready    temp_centi[23:0], press_pa[31:0], press_invalid
//   cfg      in   cfg_we         cfg_index[2:0], cfg_data[31:0]
//
// One word is accepted per cycle while the output word does not wait; the
// pipe has 8 arithmetic stages, 32 divider stages and 3 correction stages.
// The whole pipe holds when the output word waits, so nothing is lost or
// repeated. arst_n clears the valid bits and trim registers.
`timescale 1ns / 1ps

module baro_temp_press_compensation_core import bptc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	bptc_in_if.sink              in_ch,
	bptc_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	logic [31:0] cal_q [NUM_CAL_REGS];
	trim_t       trim;
	logic        adv;
	logic        f_vld, d_vld, b_vld;
	div_word_t   f_word, d_word;

	// Write trim registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CAL_REGS; i++) begin
				cal_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_T1_T2: cal_q[0] <= cfg_data;
				REG_T3_P1: cal_q[1] <= cfg_data;
				REG_P2_P3: cal_q[2] <= cfg_data;
				REG_P4_P5: cal_q[3] <= cfg_data;
				REG_P6_P7: cal_q[4] <= cfg_data;
				REG_P8_P9: cal_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack trim words
	always_comb begin
		trim.t1 = {16'd0, cal_q[0][15:0]};
		trim.t2 = sext16(cal_q[0][31:16]);
		trim.t3 = sext16(cal_q[1][15:0]);
		trim.p1 = {16'd0, cal_q[1][31:16]};
		trim.p2 = sext16(cal_q[2][15:0]);
		trim.p3 = sext16(cal_q[2][31:16]);
		trim.p4 = sext16(cal_q[3][15:0]);
		trim.p5 = sext16(cal_q[3][31:16]);
		trim.p6 = sext16(cal_q[4][15:0]);
		trim.p7 = sext16(cal_q[4][31:16]);
		trim.p8 = sext16(cal_q[5][15:0]);
		trim.p9 = sext16(cal_q[5][31:16]);
	end

	// Hold the pipe only while the output word waits
	assign adv         = !b_vld || out_ch.ready;
	assign in_ch.ready = adv;
	assign out_ch.valid = b_vld;

	bptc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_vld    (in_ch.valid),
		.raw_temp  (in_ch.raw_temp),
		.raw_press (in_ch.raw_press),
		.trim      (trim),
		.out_vld   (f_vld),
		.out_word  (f_word)
	);

	bptc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (f_vld),
		.in_word  (f_word),
		.out_vld  (d_vld),
		.out_word (d_word)
	);

	bptc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_vld        (d_vld),
		.in_word       (d_word),
		.trim          (trim),
		.out_vld       (b_vld),
		.temp_centi    (out_ch.temp_centi),
		.press_pa      (out_ch.press_pa),
		.press_invalid (out_ch.press_invalid)
	);

endmodule

// File: rtl/bptc_front.sv
// Temperature formula and pressure divisor/dividend, eight register stages.
// Depends on bptc_pkg.
`timescale 1ns / 1ps

module bptc_front import bptc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_vld,
	input  logic [19:0] raw_temp,
	input  logic [19:0] raw_press,
	input  trim_t       trim,
	output logic        out_vld,
	output div_word_t   out_word
);

	logic [7:0] vld_q;

	logic [31:0] at_s1, bb_s1;
	logic [19:0] ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6;
	logic [31:0] v1t_s2, x_s2;
	logic [31:0] fine_s3;
	logic [23:0] temp_s4, temp_s5, temp_s6, temp_s7;
	logic [31:0] v1_s4, sq_s4;
	logic [31:0] m6_s5, m5_s5, m3_s5, m2_s5;
	logic [31:0] v2_s6, v1b_s6;
	logic [31:0] md_s7, pn_s7;
	div_word_t   w_s8;

	logic [31:0] a_c, b_c, t5_c, temp_c, v1_c, q_c, pd_c;

	always_comb begin
		a_c    = {15'd0, raw_temp[19:3]} - {trim.t1[30:0], 1'b0};
		b_c    = {16'd0, raw_temp[19:4]} - trim.t1;
		t5_c   = {fine_s3[29:0], 2'b00} + fine_s3 + 32'd128;
		temp_c = asr32(t5_c, 8);
		v1_c   = asr32(fine_s3, 1) - 32'd64000;
		q_c    = asr32(v1_c, 2);
		pd_c   = (32'd1048576 - {12'd0, ap_s6}) - asr32(v2_s6, 12);
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[6:0], in_vld};
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			at_s1   <= a_c * trim.t2;
			bb_s1   <= b_c * b_c;
			ap_s1   <= raw_press;

			v1t_s2  <= asr32(at_s1, 11);
			x_s2    <= asr32(bb_s1, 12) * trim.t3;
			ap_s2   <= ap_s1;

			fine_s3 <= v1t_s2 + asr32(x_s2, 14);
			ap_s3   <= ap_s2;

			temp_s4 <= temp_c[23:0];
			v1_s4   <= v1_c;
			sq_s4   <= q_c * q_c;
			ap_s4   <= ap_s3;

			m6_s5   <= asr32(sq_s4, 11) * trim.p6;
			m5_s5   <= v1_s4 * trim.p5;
			m3_s5   <= trim.p3 * asr32(sq_s4, 13);
			m2_s5   <= trim.p2 * v1_s4;
			temp_s5 <= temp_s4;
			ap_s5   <= ap_s4;

			v2_s6   <= asr32(m6_s5 + {m5_s5[30:0], 1'b0}, 2) + {trim.p4[15:0], 16'd0};
			v1b_s6  <= asr32(asr32(m3_s5, 3) + asr32(m2_s5, 1), 18);
			temp_s6 <= temp_s5;
			ap_s6   <= ap_s5;

			md_s7   <= (32'd32768 + v1b_s6) * trim.p1;
			pn_s7   <= pd_c * 32'd3125;
			temp_s7 <= temp_s6;

			// Keep the dividend in range: large values divide first, then double; others double first
			w_s8.temp <= temp_s7;
			w_s8.dvs  <= asr32(md_s7, 15);
			w_s8.inv  <= (asr32(md_s7, 15) == 32'd0);
			w_s8.dbl  <= pn_s7[31];
			w_s8.num  <= pn_s7[31] ? pn_s7 : {pn_s7[30:0], 1'b0};
			w_s8.rem  <= '0;
			w_s8.quo  <= '0;
		end
	end

	assign out_vld  = vld_q[7];
	assign out_word = w_s8;

endmodule

// File: rtl/bptc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on bptc_pkg.
`timescale 1ns / 1ps

module bptc_div import bptc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  logic      in_vld,
	input  div_word_t in_word,
	output logic      out_vld,
	output div_word_t out_word
);

	logic      [DIV_STAGES-1:0] vld_q;
	div_word_t                  w_q [DIV_STAGES];
	div_word_t                  src [DIV_STAGES];
	div_word_t                  nxt [DIV_STAGES];

	// One restoring step per stage
	always_comb begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			logic [32:0] t;
			logic [32:0] d;
			src[k] = (k == 0) ? in_word : w_q[(k == 0) ? 0 : k - 1];
			t = {src[k].rem, src[k].num[31]};
			d = t - {1'b0, src[k].dvs};
			nxt[k] = src[k];
			nxt[k].num = {src[k].num[30:0], 1'b0};
			if (!d[32]) begin
				nxt[k].rem = d[31:0];
				nxt[k].quo = {src[k].quo[30:0], 1'b1};
			end else begin
				nxt[k].rem = t[31:0];
				nxt[k].quo = {src[k].quo[30:0], 1'b0};
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DIV_STAGES-2:0], in_vld};
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				w_q[k] <= nxt[k];
			end
		end
	end

	assign out_vld  = vld_q[DIV_STAGES-1];
	assign out_word = w_q[DIV_STAGES-1];

endmodule

// File: rtl/bptc_back.sv
// Pressure correction after the divide, three stages, last one is the output.
// Depends on bptc_pkg.
`timescale 1ns / 1ps

module bptc_back import bptc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_vld,
	input  div_word_t   in_word,
	input  trim_t       trim,
	output logic        out_vld,
	output logic [23:0] temp_centi,
	output logic [31:0] press_pa,
	output logic        press_invalid
);

	logic [2:0]  vld_q;
	logic [31:0] p_s1, sq_s1, m8_s1, p_s2, w1_s2, w2_s2;
	logic [23:0] temp_s1, temp_s2, temp_s3;
	logic        inv_s1, inv_s2, inv_s3;
	logic [31:0] press_s3;
	logic [31:0] pv_c, p3_c;

	always_comb begin
		pv_c = in_word.dbl ? {in_word.quo[30:0], 1'b0} : in_word.quo;
		p3_c = {3'd0, pv_c[31:3]};
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[1:0], in_vld};
		end
	end

	// Advance payload; a zero divisor forces the pressure to zero
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1     <= pv_c;
			sq_s1    <= p3_c * p3_c;
			m8_s1    <= {2'd0, pv_c[31:2]} * trim.p8;
			temp_s1  <= in_word.temp;
			inv_s1   <= in_word.inv;

			p_s2     <= p_s1;
			w1_s2    <= asr32(trim.p9 * {13'd0, sq_s1[31:13]}, 12);
			w2_s2    <= asr32(m8_s1, 13);
			temp_s2  <= temp_s1;
			inv_s2   <= inv_s1;

			press_s3 <= inv_s2 ? 32'd0 : p_s2 + asr32(w1_s2 + w2_s2 + trim.p7, 4);
			temp_s3  <= temp_s2;
			inv_s3   <= inv_s2;
		end
	end

	assign out_vld       = vld_q[2];
	assign temp_centi    = temp_s3;
	assign press_pa      = press_s3;
	assign press_invalid = inv_s3;

endmodule

// File: rtl/bptc_checker.sv
// Port-level checks for the barometer compensation core, bound to the top.
// Depends on baro_temp_press_compensation_core_assert.svh.
`timescale 1ns / 1ps
`include "baro_temp_press_compensation_core_assert.svh"

module bptc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] press_pa,
	input logic        press_invalid
);

	// Hold a stalled output word
	`BPTC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "output word dropped while stalled")

	// Zero-divisor words carry zero pressure
	`BPTC_ASSERT_IMPL(a_inv_zero, clk, arst_n, out_valid && press_invalid, press_pa == 32'd0, "invalid pressure not zero")

	// Input stalls when the output word waits and is free when the output is empty
	`BPTC_ASSERT_IMPL(a_stall_in, clk, arst_n, out_valid && !out_ready, !in_ready, "input taken during output stall")
	`BPTC_ASSERT_IMPL(a_free_in, clk, arst_n, !out_valid, in_ready, "input refused while output empty")

endmodule

bind baro_temp_press_compensation_core bptc_checker u_bptc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.press_pa      (out_ch.press_pa),
	.press_invalid (out_ch.press_invalid)
);
